// ===== hw/rtl/pstg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pstg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int COLUMN_BITS    = 12;

  localparam int QUARTER_BITS  = SINE_ADDR_BITS - 2;
  localparam int QUARTER_DEPTH = 1 << QUARTER_BITS;
  localparam int X_BITS        = 16;

  localparam int WIDTH_BITS  = COLUMN_BITS + 1;
  localparam int VOL_BITS    = 16;
  localparam int QUO_BITS    = 16;
  localparam int QCNT_BITS   = $clog2(QUO_BITS);
  localparam int ACC_BITS    = QUO_BITS + VOL_BITS;
  localparam int EXTRA_BITS  = VOL_BITS + 2;
  localparam int GAIN_BITS   = VOL_BITS + 3;
  localparam int MAG_BITS    = 15;
  localparam int MCNT_BITS   = $clog2(MAG_BITS);
  localparam int PROD_BITS   = MAG_BITS + GAIN_BITS;
  localparam int FRAC_BITS   = 15;
  localparam int P_BITS      = PROD_BITS - FRAC_BITS;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_GAIN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 2'd2;

  localparam logic [VOL_BITS-1:0]   BASE_GAIN_RST   = 16'd16384;
  localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RST = WIDTH_BITS'(640);

  localparam longint unsigned POLY_A = 64'd102944;
  localparam longint unsigned POLY_B = 64'd42048;
  localparam longint unsigned POLY_C = 64'd4640;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAN,
    ST_MUL,
    ST_HOLD
  } pstg_state_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0] left_gain;
    logic [GAIN_BITS-1:0] right_gain;
  } gain_pair_t;

  typedef logic [MAG_BITS-1:0] sine_tab_t [0:QUARTER_DEPTH];

  // Quarter-wave magnitude, odd polynomial in x (Q0.16)
  function automatic logic [MAG_BITS-1:0] sine_mag(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = longint'(idx) << (X_BITS - QUARTER_BITS);
    x2 = (x * x) >> 16;
    t  = POLY_B - ((POLY_C * x2) >> 16);
    t  = POLY_A - ((x2 * t) >> 16);
    s  = (x * t) >> 16;
    s  = s >> 1;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return MAG_BITS'(s);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i <= QUARTER_DEPTH; i++) begin
      tab[i] = sine_mag(i);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

// ===== hw/rtl/pstg_pan.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pstg_pan
  import pstg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   gap_valid_i,
  input  wire logic [COLUMN_BITS-1:0] gap_start_i,
  input  wire logic [COLUMN_BITS-1:0] gap_end_i,
  input  wire logic [WIDTH_BITS-1:0]  width_i,
  input  wire logic [VOL_BITS-1:0]    volume_i,
  output logic                        done_o,
  output gain_pair_t                  gains_o
);

  logic [WIDTH_BITS-1:0] sum;
  logic [WIDTH_BITS-1:0] num;
  logic                  left_side;

  logic [WIDTH_BITS-1:0] rem_q, rem_d;
  logic [WIDTH_BITS-1:0] w_q;
  logic [VOL_BITS-1:0]   vol_q;
  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic [QCNT_BITS-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic                  left_q, full_q, gap_q;

  logic [WIDTH_BITS:0]   rem2;
  logic [WIDTH_BITS:0]   diff;
  logic                  qbit;
  logic [EXTRA_BITS-1:0] extra;
  logic [GAIN_BITS-1:0]  gain;
  logic [GAIN_BITS-1:0]  base;

  assign sum       = WIDTH_BITS'(gap_start_i) + WIDTH_BITS'(gap_end_i);
  assign left_side = sum < width_i;
  assign num       = left_side ? (width_i - sum) : (sum - width_i);

  // One restoring divide step; quotient bits arrive MSB first and feed the
  // shift-add product volume * quotient on the fly
  assign rem2  = {rem_q, 1'b0};
  assign diff  = rem2 - {1'b0, w_q};
  assign qbit  = rem2 >= {1'b0, w_q};
  assign rem_d = qbit ? diff[WIDTH_BITS-1:0] : rem2[WIDTH_BITS-1:0];
  assign acc_d = {acc_q[ACC_BITS-2:0], 1'b0} + (qbit ? ACC_BITS'(vol_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == QCNT_BITS'(QUO_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num;
      w_q    <= width_i;
      vol_q  <= volume_i;
      acc_q  <= '0;
      left_q <= left_side;
      full_q <= num >= width_i;
      gap_q  <= gap_valid_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  // gain = volume * (1 + 4d); a full distance gives five times the volume
  assign extra = full_q ? {vol_q, 2'b00} : acc_q[ACC_BITS-1 -: EXTRA_BITS];
  assign base  = GAIN_BITS'(vol_q);
  assign gain  = base + GAIN_BITS'(extra);

  always_comb begin
    gains_o.left_gain  = (gap_q && left_q)  ? gain : base;
    gains_o.right_gain = (gap_q && !left_q) ? gain : base;
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pstg_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pstg_mul
  import pstg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [MAG_BITS-1:0]   mag_i,
  input  wire logic                  neg_i,
  input  gain_pair_t                 gains_i,
  output logic                       done_o,
  output logic [SAMPLE_BITS-1:0]     left_o,
  output logic [SAMPLE_BITS-1:0]     right_o
);

  logic [MAG_BITS-1:0]  mag_q;
  logic                 neg_q;
  gain_pair_t           gains_q;
  logic [PROD_BITS-1:0] lacc_q, racc_q;
  logic [MCNT_BITS-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  // Truncate toward zero, apply the sign, saturate to 16 bits
  function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [P_BITS-1:0] p,
                                                       input logic neg);
    logic [SAMPLE_BITS-1:0] m;
    if (neg) begin
      m = (p > P_BITS'(32768)) ? 16'h8000 : p[SAMPLE_BITS-1:0];
      return ~m + 1'b1;
    end
    return (p > P_BITS'(32767)) ? 16'h7fff : p[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MCNT_BITS'(MAG_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add, magnitude bits MSB first, both channels side by side
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q   <= mag_i;
      neg_q   <= neg_i;
      gains_q <= gains_i;
      lacc_q  <= '0;
      racc_q  <= '0;
    end else if (busy_q) begin
      mag_q  <= {mag_q[MAG_BITS-2:0], 1'b0};
      lacc_q <= {lacc_q[PROD_BITS-2:0], 1'b0}
                + (mag_q[MAG_BITS-1] ? PROD_BITS'(gains_q.left_gain) : '0);
      racc_q <= {racc_q[PROD_BITS-2:0], 1'b0}
                + (mag_q[MAG_BITS-1] ? PROD_BITS'(gains_q.right_gain) : '0);
    end
  end

  assign left_o  = to_sample(lacc_q[PROD_BITS-1 -: P_BITS], neg_q);
  assign right_o = to_sample(racc_q[PROD_BITS-1 -: P_BITS], neg_q);
  assign done_o  = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/panned_stereo_tone_generator_top.sv =====
// Per word: accept, 16 serial divide steps (which also build the gain product), hand-over,
// 15 serial multiply steps and the output load, which waits in ST_HOLD while the output
// register is full. s_axis_tready is high only in ST_IDLE, so no new word is accepted
// before the previous word has been loaded into the output register.
// The output register holds a finished word while the next one is computed.
// Reset (rst_ni low, asynchronous): phase 0, phase_step 0, base gain 16384,
// image_width 640, no word pending.
`timescale 1ns / 1ps
`default_nettype none
module panned_stereo_tone_generator_top
  import pstg_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [23:0]              s_axis_tdata,  // gap_start, gap_end
  input  wire logic [0:0]               s_axis_tuser,  // gap_valid
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [31:0]                   m_axis_tdata   // left_sample, right_sample
);

  logic [PHASE_BITS-1:0] phase_step_q;
  logic [VOL_BITS-1:0]   base_gain_q;
  logic [WIDTH_BITS-1:0] image_width_q;
  logic [PHASE_BITS-1:0] phase_acc_q;

  pstg_state_e state_q, state_d;
  logic        accept;
  logic        pan_done, mul_done;
  logic        mul_start;
  logic        out_load;
  logic        out_free;
  gain_pair_t  gains;

  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QUARTER_BITS-1:0]   qidx;
  logic [QUARTER_BITS:0]     tidx;
  logic [MAG_BITS-1:0]       mag_q;
  logic                      neg_q;

  logic [SAMPLE_BITS-1:0] left_s, right_s;
  logic                   m_valid_q;
  logic [31:0]            m_data_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      base_gain_q   <= BASE_GAIN_RST;
      image_width_q <= IMAGE_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i[PHASE_BITS-1:0];
        CFG_BASE_GAIN:   base_gain_q   <= cfg_data_i[VOL_BITS-1:0];
        CFG_IMAGE_WIDTH: image_width_q <= cfg_data_i[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sine from the phase held before this word; quarter-wave folding
  assign addr = phase_acc_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  assign qidx = addr[QUARTER_BITS-1:0];
  assign tidx = quad[0] ? ((QUARTER_BITS+1)'(QUARTER_DEPTH) - {1'b0, qidx})
                        : {1'b0, qidx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
    end else if (accept) begin
      phase_acc_q <= phase_acc_q + phase_step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q <= SINE_TAB[tidx];
      neg_q <= quad[1];
    end
  end

  pstg_pan u_pan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .gap_valid_i (s_axis_tuser[0]),
    .gap_start_i (s_axis_tdata[11:0]),
    .gap_end_i   (s_axis_tdata[23:12]),
    .width_i     (image_width_q),
    .volume_i    (base_gain_q),
    .done_o      (pan_done),
    .gains_o     (gains)
  );

  pstg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (mag_q),
    .neg_i   (neg_q),
    .gains_i (gains),
    .done_o  (mul_done),
    .left_o  (left_s),
    .right_o (right_s)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PAN;
        end
      end
      ST_PAN: begin
        if (pan_done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {right_s, left_s};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== dv/tb_panned_stereo_tone_generator_top.sv =====
`timescale 1ns / 1ps
module tb_panned_stereo_tone_generator_top;
  import pstg_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  // Sine polynomial coefficients, Q16
  localparam longint unsigned SIN_K1 = 102944;
  localparam longint unsigned SIN_K3 = 42048;
  localparam longint unsigned SIN_K5 = 4640;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 10;
  localparam int WORDS_PER_PHASE = 165;

  typedef struct {
    logic                   gap_valid;
    logic [COLUMN_BITS-1:0] gap_start;
    logic [COLUMN_BITS-1:0] gap_end;
  } gap_word_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } stereo_frame_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [23:0]              s_axis_tdata = '0;  // gap_start, gap_end
  logic [0:0]               s_axis_tuser = '0;  // gap_valid
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [31:0]              m_axis_tdata;       // left_sample, right_sample

  panned_stereo_tone_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Tone generator state as the block should hold it
  logic [31:0] tone_phase = '0;
  logic [31:0] tone_step  = '0;
  logic [15:0] gain_base  = 16'd16384;
  logic [12:0] cols_width = 13'd640;

  gap_word_t     pending_words[$];
  stereo_frame_t frames_due[$];
  int            mismatches = 0;

  function automatic logic [14:0] sine_magnitude(input logic [SINE_ADDR_BITS-1:0] addr);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x = addr[QUARTER_BITS-1:0];
    x = x << (16 - QUARTER_BITS);
    // mirror odd quadrants; x reaches 1.0 at the peak
    if (addr[QUARTER_BITS]) x = 65536 - x;
    x2 = (x * x) >> 16;
    t  = SIN_K3 - ((SIN_K5 * x2) >> 16);
    t  = SIN_K1 - ((x2 * t) >> 16);
    s  = ((x * t) >> 16) >> 1;
    if (s > 32767) s = 32767;
    return s[14:0];
  endfunction

  function automatic logic [15:0] scaled_sample(input logic [14:0] mag, input logic neg,
                                                input longint unsigned gain);
    longint unsigned p;
    logic [15:0]     r;
    p = mag;
    p = (p * gain) >> 15;
    if (neg) begin
      if (p > 32768) p = 32768;
      r = p[15:0];
      r = -r;
    end else begin
      if (p > 32767) p = 32767;
      r = p[15:0];
    end
    return r;
  endfunction

  function automatic stereo_frame_t predict_frame(input gap_word_t w);
    longint unsigned base;
    longint unsigned lg;
    longint unsigned rg;
    longint unsigned sum;
    longint unsigned wd;
    longint unsigned num;
    longint unsigned d;
    longint unsigned g;
    logic            near_left;
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [14:0]     mag;
    stereo_frame_t   f;
    base = gain_base;
    lg = base;
    rg = base;
    if (w.gap_valid) begin
      sum = w.gap_start;
      sum = sum + w.gap_end;
      wd  = cols_width;
      near_left = sum < wd;
      num = near_left ? wd - sum : sum - wd;
      // zero width falls into the clamp, so no divide by zero
      d = (num >= wd) ? 65536 : (num << 16) / wd;
      g = (base * (65536 + 4 * d)) >> 16;
      if (near_left) lg = g;
      else rg = g;
    end
    addr = tone_phase[31 -: SINE_ADDR_BITS];
    mag = sine_magnitude(addr);
    f.left  = scaled_sample(mag, addr[SINE_ADDR_BITS-1], lg);
    f.right = scaled_sample(mag, addr[SINE_ADDR_BITS-1], rg);
    return f;
  endfunction

  bit word_taken = 1'b0;

  // Track register writes and accepted words; predict at acceptance
  always @(posedge clk_i) begin : p_accept
    gap_word_t w;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP:  tone_step  = cfg_data_i;
        CFG_BASE_GAIN:   gain_base  = cfg_data_i[15:0];
        CFG_IMAGE_WIDTH: cols_width = cfg_data_i[12:0];
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      w.gap_start = s_axis_tdata[11:0];
      w.gap_end   = s_axis_tdata[23:12];
      w.gap_valid = s_axis_tuser[0];
      frames_due.push_back(predict_frame(w));
      tone_phase = tone_phase + tone_step;
      word_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin : p_monitor
    stereo_frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (m_axis_tdata[15:0] !== want.left) begin
          $display("%0t: left_sample expected %0d actual %0d", $time,
                   $signed(want.left), $signed(m_axis_tdata[15:0]));
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== want.right) begin
          $display("%0t: right_sample expected %0d actual %0d", $time,
                   $signed(want.right), $signed(m_axis_tdata[31:16]));
          mismatches++;
        end
      end
    end
  end

  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk_i) begin : p_drive
    gap_word_t w;
    logic      next_valid;
    next_valid = s_axis_tvalid && !word_taken;
    word_taken = 1'b0;
    if (rst_ni && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        s_axis_tdata <= {w.gap_end, w.gap_start};
        s_axis_tuser <= w.gap_valid;
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = 40;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 6);
            gap_left = $urandom_range(0, 60);
          end
        end
      end
    end
    s_axis_tvalid <= next_valid;
  end

  int ready_run = 0;

  always @(negedge clk_i) begin : p_sink
    logic level;
    level = m_axis_tready;
    if (ready_run > 0) begin
      ready_run--;
    end else begin
      level = ~level;
      if (!level) begin
        ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                                : $urandom_range(1, 8);
      end else begin
        ready_run = ($urandom_range(0, 9) == 0) ? 500 : $urandom_range(1, 50);
      end
    end
    m_axis_tready <= level;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic queue_word(input logic v, input int start_col, input int end_col);
    gap_word_t w;
    w.gap_valid = v;
    w.gap_start = start_col[11:0];
    w.gap_end   = end_col[11:0];
    pending_words.push_back(w);
  endtask

  // Hold until every word is through, then let the pipeline settle
  task automatic drain_words();
    while (pending_words.size() != 0 || s_axis_tvalid || frames_due.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [31:0] step;
    logic [31:0] vol;
    logic [31:0] wd;
    case ($urandom_range(0, 4))
      0: step = 32'hFFFF_FFFF;
      1: step = $urandom_range(0, 1 << 24);
      2: step = 32'd0;
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: vol = 32'd0;
      1: vol = 32'd32768;
      2: vol = 32'd65535;
      3: vol = $urandom;
      default: vol = $urandom_range(0, 32768);
    endcase
    case ($urandom_range(0, 6))
      0: wd = 32'd0;
      1: wd = 32'd1;
      2: wd = 32'd4096;
      3: wd = 32'd8191;
      4: wd = $urandom;
      default: wd = $urandom_range(1, 4096);
    endcase
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_BASE_GAIN, vol);
    write_reg(CFG_IMAGE_WIDTH, wd);
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  task automatic queue_random_word();
    int wd;
    int s;
    int e;
    int sum;
    wd = cols_width;
    s = $urandom_range(0, 4095);
    e = $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0: queue_word(1'b0, s, e);
      1: begin
        // centred gap
        if (wd <= 8190) begin
          s = $urandom_range(0, (wd > 4095) ? 4095 : wd);
          e = wd - s;
          if (e > 4095) begin
            e = 4095;
            s = wd - e;
          end
        end
        queue_word(1'b1, s, e);
      end
      2: queue_word(1'b1, $urandom_range(0, 1) ? 4095 : 0, $urandom_range(0, 1) ? 4095 : 0);
      3: begin
        // sum just either side of the width
        sum = wd + $urandom_range(0, 6) - 3;
        if (sum < 0) sum = 0;
        if (sum > 8190) sum = 8190;
        s = sum / 2;
        queue_word(1'b1, s, sum - s);
      end
      default: queue_word(1'b1, s, e);
    endcase
  endtask

  initial begin : p_stimulus
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset volume and width, quarter-turn phases
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    queue_word(1'b0, 100, 200);
    queue_word(1'b1, 320, 320);
    queue_word(1'b1, 0, 0);
    queue_word(1'b1, 4095, 4095);
    queue_word(1'b1, 4095, 0);
    queue_word(1'b1, 12'hAAA, 12'h555);
    queue_word(1'b1, 319, 320);
    queue_word(1'b1, 320, 321);
    drain_words();

    // Zero width and volume above unity: saturate the right channel
    write_reg(CFG_BASE_GAIN, 32'd65535);
    write_reg(CFG_IMAGE_WIDTH, 32'd0);
    queue_word(1'b1, 0, 0);
    queue_word(1'b1, 4095, 4095);
    queue_word(1'b0, 0, 0);
    queue_word(1'b1, 1, 0);
    drain_words();

    // Widest image: saturate the left channel
    write_reg(CFG_PHASE_STEP, 32'hC000_0000);
    write_reg(CFG_IMAGE_WIDTH, 32'd8191);
    queue_word(1'b1, 0, 0);
    queue_word(1'b1, 0, 0);
    queue_word(1'b1, 0, 0);
    queue_word(1'b1, 0, 0);
    queue_word(1'b1, 4095, 4095);
    drain_words();

    // Silent volume, unused index ignored
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_BASE_GAIN, 32'd0);
    write_reg(CFG_IMAGE_WIDTH, 32'd1);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_word(1'b1, 0, 1);
    queue_word(1'b1, 4095, 0);
    drain_words();

    write_reg(CFG_PHASE_STEP, 32'h0123_4567);
    write_reg(CFG_BASE_GAIN, 32'd32768);
    write_reg(CFG_IMAGE_WIDTH, 32'd4096);
    for (int i = 0; i < WORDS_PER_PHASE; i++) queue_random_word();
    drain_words();

    for (int p = 1; p < PHASES; p++) begin
      random_settings();
      for (int i = 0; i < WORDS_PER_PHASE; i++) queue_random_word();
      drain_words();
    end

    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : p_watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
